### hw/rtl/ilr_pkg.sv
// ----------------------------------------------------------------------------
// ilr_pkg
// Shared types, widths, codes and the endpoint conversion of the isometric
// line rasteriser.
// ----------------------------------------------------------------------------
package ilr_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int POS_W      = 32;
  localparam int GRID_W     = 10;
  localparam int ZOOM_W     = 8;
  localparam int FACT_W     = 16;
  localparam int SHIFT_W    = 13;
  localparam int Z_W        = 16;
  localparam int COLOR_W    = 24;
  localparam int PIX_W      = 16;
  localparam int SPAN_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int ZW = GRID_W + 1 + ZOOM_W;
  localparam int PW = ZW + 2 + FACT_W;
  localparam int EW = PW + 2;
  localparam int DW = POS_W + 1;

  localparam int CLAMP_BITS = ((31 - FRAC_BITS) < 15) ? (31 - FRAC_BITS) : 15;
  localparam int UP_SH      = (FRAC_BITS >= 14) ? (FRAC_BITS - 14) : 0;
  localparam int DOWN_SH    = (FRAC_BITS < 14) ? (14 - FRAC_BITS) : 0;
  localparam int QBITS      = FRAC_BITS + 1;
  localparam int CNT_W      = $clog2(QBITS);

  localparam logic signed [EW-1:0] SAT_HI = EW'((64'sd1 <<< (CLAMP_BITS + 14)) - 64'sd1);
  localparam logic signed [EW-1:0] SAT_LO = EW'(-(64'sd1 <<< (CLAMP_BITS + 14)));

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ZOOM    = 3'd0,
    CFG_COS     = 3'd1,
    CFG_SIN     = 3'd2,
    CFG_SHIFT_X = 3'd3,
    CFG_SHIFT_Y = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SPAN = 2'd1,
    ST_DIV  = 2'd2
  } back_state_e;

  typedef struct packed {
    logic        [ZOOM_W-1:0]  zoom;
    logic signed [FACT_W-1:0]  cos_f;
    logic signed [FACT_W-1:0]  sin_f;
    logic signed [SHIFT_W-1:0] shift_x;
    logic signed [SHIFT_W-1:0] shift_y;
  } cfg_t;

  typedef struct packed {
    logic                    is_load;
    logic signed [POS_W-1:0] x0;
    logic signed [POS_W-1:0] y0;
    logic signed [POS_W-1:0] x1;
    logic signed [POS_W-1:0] y1;
    logic [COLOR_W-1:0]      color;
  } cmd_t;

  // saturate a q.14 coordinate and rescale it to the position format
  function automatic logic signed [POS_W-1:0] to_pos(logic signed [EW-1:0] v);
    logic signed [EW-1:0] s;
    logic signed [EW-1:0] t;
    if (v > SAT_HI) begin
      s = SAT_HI;
    end else if (v < SAT_LO) begin
      s = SAT_LO;
    end else begin
      s = v;
    end
    t = (s <<< UP_SH) >>> DOWN_SH;
    return t[POS_W-1:0];
  endfunction

endpackage

### hw/rtl/isometric_line_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// isometric_line_rasterizer_unit
// Isometric line rasteriser: projects grid segments and emits DDA pixels.
// ----------------------------------------------------------------------------
// A tick item yields at most one pixel and, once the queue is primed, the
// back side emits one pixel per cycle while pop keeps the result slot free;
// every item passes the zoom and projection registers on its way to the
// command queue. A load is taken while idle, its span found and its step
// division run bit-serially while later items wait in the four-entry queue.
// The user must write registers via cfg_we_i/cfg_idx_i/cfg_data_i only while
// the unit is idle; the block does not enforce it. Unused indexes are ignored.
module isometric_line_rasterizer_unit import ilr_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                      push,
  output logic                      full,
  input  logic                      cmd_i,
  input  logic [GRID_W-1:0]         grid_x_i,
  input  logic [GRID_W-1:0]         grid_y_i,
  input  logic                      direction_i,
  input  logic signed [Z_W-1:0]     z_start_i,
  input  logic signed [Z_W-1:0]     z_end_i,
  input  logic [COLOR_W-1:0]        color_i,
  output logic                      empty,
  input  logic                      pop,
  output logic signed [PIX_W-1:0]   pixel_x_o,
  output logic signed [PIX_W-1:0]   pixel_y_o,
  output logic [COLOR_W-1:0]        pixel_color_o,
  output logic                      last_o
);

  cfg_t cfg_q;
  logic cmd_valid, cmd_full, q_empty, q_pop;
  cmd_t cmd_wr, cmd_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.zoom    <= ZOOM_W'(20);
      cfg_q.cos_f   <= FACT_W'(11415);
      cfg_q.sin_f   <= FACT_W'(11754);
      cfg_q.shift_x <= '0;
      cfg_q.shift_y <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ZOOM:    cfg_q.zoom    <= cfg_data_i[ZOOM_W-1:0];
        CFG_COS:     cfg_q.cos_f   <= cfg_data_i[FACT_W-1:0];
        CFG_SIN:     cfg_q.sin_f   <= cfg_data_i[FACT_W-1:0];
        CFG_SHIFT_X: cfg_q.shift_x <= cfg_data_i[SHIFT_W-1:0];
        CFG_SHIFT_Y: cfg_q.shift_y <= cfg_data_i[SHIFT_W-1:0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  ilr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .push        (push),
    .full        (full),
    .cmd_i       (cmd_i),
    .grid_x_i    (grid_x_i),
    .grid_y_i    (grid_y_i),
    .direction_i (direction_i),
    .z_start_i   (z_start_i),
    .z_end_i     (z_end_i),
    .color_i     (color_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd_wr),
    .cmd_full_i  (cmd_full)
  );

  ilr_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (cmd_valid),
    .wr_data_i (cmd_wr),
    .full_o    (cmd_full),
    .rd_i      (q_pop),
    .rd_data_o (cmd_rd),
    .empty_o   (q_empty)
  );

  ilr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_data_i      (cmd_rd),
    .q_pop_o       (q_pop),
    .empty         (empty),
    .pop           (pop),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_color_o (pixel_color_o),
    .last_o        (last_o)
  );

endmodule

### hw/rtl/ilr_front.sv
// ----------------------------------------------------------------------------
// ilr_front
// Input side: takes items, zooms and projects both endpoints in a short
// multiplier pipeline and hands classified commands to the queue.
// ----------------------------------------------------------------------------
module ilr_front import ilr_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cfg_t                      cfg_i,
  input  logic                      push,
  output logic                      full,
  input  logic                      cmd_i,
  input  logic [GRID_W-1:0]         grid_x_i,
  input  logic [GRID_W-1:0]         grid_y_i,
  input  logic                      direction_i,
  input  logic signed [Z_W-1:0]     z_start_i,
  input  logic signed [Z_W-1:0]     z_end_i,
  input  logic [COLOR_W-1:0]        color_i,
  output logic                      cmd_valid_o,
  output cmd_t                      cmd_o,
  input  logic                      cmd_full_i
);

  logic adv;

  logic                  s1_valid_q;
  logic                  s1_load_q;
  logic [ZW-1:0]         s1_xa_q, s1_ya_q, s1_xb_q, s1_yb_q;
  logic signed [Z_W-1:0] s1_za_q, s1_zb_q;
  logic [COLOR_W-1:0]    s1_color_q;

  logic                  s2_valid_q;
  logic                  s2_load_q;
  logic signed [PW-1:0]  s2_pxa_q, s2_pya_q, s2_pxb_q, s2_pyb_q;
  logic signed [Z_W-1:0] s2_za_q, s2_zb_q;
  logic [COLOR_W-1:0]    s2_color_q;

  logic [GRID_W:0]       gx_end, gy_end;
  logic signed [ZW:0]    diff_a, diff_b;
  logic signed [ZW+1:0]  sum_a, sum_b;
  logic signed [EW-1:0]  ex_a, ey_a, ex_b, ey_b;

  assign adv  = !(s2_valid_q && cmd_full_i);
  assign full = !adv;

  assign gx_end = {1'b0, grid_x_i} + {{GRID_W{1'b0}}, ~direction_i};
  assign gy_end = {1'b0, grid_y_i} + {{GRID_W{1'b0}}, direction_i};

  assign diff_a = $signed({1'b0, s1_xa_q}) - $signed({1'b0, s1_ya_q});
  assign diff_b = $signed({1'b0, s1_xb_q}) - $signed({1'b0, s1_yb_q});
  assign sum_a  = $signed({2'b00, s1_xa_q}) + $signed({2'b00, s1_ya_q});
  assign sum_b  = $signed({2'b00, s1_xb_q}) + $signed({2'b00, s1_yb_q});

  assign ex_a = EW'(s2_pxa_q) + (EW'(cfg_i.shift_x) <<< 14);
  assign ex_b = EW'(s2_pxb_q) + (EW'(cfg_i.shift_x) <<< 14);
  assign ey_a = EW'(s2_pya_q) - (EW'(s2_za_q) <<< 14) + (EW'(cfg_i.shift_y) <<< 14);
  assign ey_b = EW'(s2_pyb_q) - (EW'(s2_zb_q) <<< 14) + (EW'(cfg_i.shift_y) <<< 14);

  always_comb begin
    cmd_o.is_load = s2_load_q;
    cmd_o.x0      = to_pos(ex_a);
    cmd_o.y0      = to_pos(ey_a);
    cmd_o.x1      = to_pos(ex_b);
    cmd_o.y1      = to_pos(ey_b);
    cmd_o.color   = s2_color_q;
  end

  assign cmd_valid_o = s2_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= push;
      s2_valid_q <= s1_valid_q;
    end
  end

  // zoom stage
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_load_q  <= (cmd_i == CMD_LOAD);
      s1_xa_q    <= ZW'(grid_x_i) * ZW'(cfg_i.zoom);
      s1_ya_q    <= ZW'(grid_y_i) * ZW'(cfg_i.zoom);
      s1_xb_q    <= ZW'(gx_end) * ZW'(cfg_i.zoom);
      s1_yb_q    <= ZW'(gy_end) * ZW'(cfg_i.zoom);
      s1_za_q    <= z_start_i;
      s1_zb_q    <= z_end_i;
      s1_color_q <= color_i;
    end
  end

  // projection stage
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_load_q  <= s1_load_q;
      s2_pxa_q   <= PW'(diff_a) * PW'(cfg_i.cos_f);
      s2_pxb_q   <= PW'(diff_b) * PW'(cfg_i.cos_f);
      s2_pya_q   <= PW'(sum_a) * PW'(cfg_i.sin_f);
      s2_pyb_q   <= PW'(sum_b) * PW'(cfg_i.sin_f);
      s2_za_q    <= s1_za_q;
      s2_zb_q    <= s1_zb_q;
      s2_color_q <= s1_color_q;
    end
  end

endmodule

### hw/rtl/ilr_fifo.sv
// ----------------------------------------------------------------------------
// ilr_fifo
// Short command queue between the projection front and the drawing back.
// ----------------------------------------------------------------------------
module ilr_fifo import ilr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  cmd_t wr_data_i,
  output logic full_o,
  input  logic rd_i,
  output cmd_t rd_data_o,
  output logic empty_o
);

  cmd_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_AW:0]   count_q;
  logic               do_wr, do_rd;

  assign full_o    = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + (FIFO_AW+1)'(1);
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - (FIFO_AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

### hw/rtl/ilr_back.sv
// ----------------------------------------------------------------------------
// ilr_back
// Drawing side: sets up a segment with a bit-serial step division and
// steps the position one pixel per tick into the result register.
// ----------------------------------------------------------------------------
module ilr_back import ilr_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_empty_i,
  input  cmd_t                      q_data_i,
  output logic                      q_pop_o,
  output logic                      empty,
  input  logic                      pop,
  output logic signed [PIX_W-1:0]   pixel_x_o,
  output logic signed [PIX_W-1:0]   pixel_y_o,
  output logic [COLOR_W-1:0]        pixel_color_o,
  output logic                      last_o
);

  back_state_e st_q, st_d;

  logic signed [POS_W-1:0] pos_x_q, pos_y_q, step_x_q, step_y_q;
  logic [SPAN_W-1:0]       pixels_left_q;
  logic [COLOR_W-1:0]      seg_color_q;
  logic signed [DW-1:0]    dx_q, dy_q;
  logic [SPAN_W-1:0]       span_q;
  logic [SPAN_W-1:0]       rem_x_q, rem_y_q;
  logic [QBITS-1:0]        dvd_x_q, dvd_y_q;
  logic [CNT_W-1:0]        cnt_q;

  logic                    out_valid_q;
  logic signed [PIX_W-1:0] out_x_q, out_y_q;
  logic [COLOR_W-1:0]      out_color_q;
  logic                    out_last_q;

  logic take_load, take_tick, emit, div_done;
  logic slot_free;

  logic [DW-1:0]           ax, ay, amax;
  logic [SPAN_W-1:0]       span_new;
  logic [SPAN_W:0]         tx, ty;
  logic                    gex, gey;
  logic [SPAN_W-1:0]       rem_x_nx, rem_y_nx;
  logic [QBITS-1:0]        q_x_nx, q_y_nx;
  logic signed [POS_W-1:0] hx, hy;
  logic signed [PIX_W-1:0] pix_x, pix_y;

  assign slot_free = !out_valid_q || pop;
  assign div_done  = (cnt_q == '0);

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (take_load) begin
          st_d = ST_SPAN;
        end
      end
      ST_SPAN: begin
        if (span_new != '0) begin
          st_d = ST_DIV;
        end else begin
          st_d = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    take_load = 1'b0;
    take_tick = 1'b0;
    emit      = 1'b0;
    case (st_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          if (q_data_i.is_load) begin
            take_load = 1'b1;
          end else if (pixels_left_q == '0) begin
            take_tick = 1'b1;
          end else if (slot_free) begin
            take_tick = 1'b1;
            emit      = 1'b1;
          end
        end
      end
      default: begin
        take_load = 1'b0;
      end
    endcase
  end

  assign q_pop_o = take_load || take_tick;

  // span and divider
  assign ax       = dx_q[DW-1] ? DW'(-dx_q) : DW'(dx_q);
  assign ay       = dy_q[DW-1] ? DW'(-dy_q) : DW'(dy_q);
  assign amax     = (ax > ay) ? ax : ay;
  assign span_new = SPAN_W'(amax >> FRAC_BITS);

  assign tx       = {rem_x_q, dvd_x_q[QBITS-1]};
  assign ty       = {rem_y_q, dvd_y_q[QBITS-1]};
  assign gex      = (tx >= {1'b0, span_q});
  assign gey      = (ty >= {1'b0, span_q});
  assign rem_x_nx = gex ? SPAN_W'(tx - {1'b0, span_q}) : tx[SPAN_W-1:0];
  assign rem_y_nx = gey ? SPAN_W'(ty - {1'b0, span_q}) : ty[SPAN_W-1:0];
  assign q_x_nx   = {dvd_x_q[QBITS-2:0], gex};
  assign q_y_nx   = {dvd_y_q[QBITS-2:0], gey};

  // truncation toward zero of the current position
  assign hx    = pos_x_q >>> FRAC_BITS;
  assign hy    = pos_y_q >>> FRAC_BITS;
  assign pix_x = hx[PIX_W-1:0] + PIX_W'(pos_x_q[POS_W-1] && (|pos_x_q[FRAC_BITS-1:0]));
  assign pix_y = hy[PIX_W-1:0] + PIX_W'(pos_y_q[POS_W-1] && (|pos_y_q[FRAC_BITS-1:0]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q          <= ST_IDLE;
      pixels_left_q <= '0;
      cnt_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      st_q <= st_d;
      if (emit) begin
        out_valid_q   <= 1'b1;
        pixels_left_q <= pixels_left_q - SPAN_W'(1);
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
      case (st_q)
        ST_SPAN: begin
          cnt_q <= CNT_W'(QBITS - 1);
          if (span_new == '0) begin
            pixels_left_q <= '0;
          end
        end
        ST_DIV: begin
          cnt_q <= cnt_q - CNT_W'(1);
          if (div_done) begin
            pixels_left_q <= span_q;
          end
        end
        default: begin
          cnt_q <= cnt_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_load) begin
      pos_x_q     <= q_data_i.x0;
      pos_y_q     <= q_data_i.y0;
      seg_color_q <= q_data_i.color;
      dx_q        <= DW'(q_data_i.x1) - DW'(q_data_i.x0);
      dy_q        <= DW'(q_data_i.y1) - DW'(q_data_i.y0);
    end else if (emit) begin
      pos_x_q <= pos_x_q + step_x_q;
      pos_y_q <= pos_y_q + step_y_q;
    end
    if (st_q == ST_SPAN) begin
      span_q  <= span_new;
      rem_x_q <= SPAN_W'(ax >> QBITS);
      rem_y_q <= SPAN_W'(ay >> QBITS);
      dvd_x_q <= ax[QBITS-1:0];
      dvd_y_q <= ay[QBITS-1:0];
      if (span_new == '0) begin
        step_x_q <= '0;
        step_y_q <= '0;
      end
    end
    if (st_q == ST_DIV) begin
      rem_x_q <= rem_x_nx;
      rem_y_q <= rem_y_nx;
      dvd_x_q <= q_x_nx;
      dvd_y_q <= q_y_nx;
      if (div_done) begin
        step_x_q <= dx_q[DW-1] ? -POS_W'(q_x_nx) : POS_W'(q_x_nx);
        step_y_q <= dy_q[DW-1] ? -POS_W'(q_y_nx) : POS_W'(q_y_nx);
      end
    end
    if (emit) begin
      out_x_q     <= pix_x;
      out_y_q     <= pix_y;
      out_color_q <= seg_color_q;
      out_last_q  <= (pixels_left_q == SPAN_W'(1));
    end
  end

  assign empty         = !out_valid_q;
  assign pixel_x_o     = out_x_q;
  assign pixel_y_o     = out_y_q;
  assign pixel_color_o = out_color_q;
  assign last_o        = out_last_q;

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_DIV) |-> (span_q != '0))
    else $error("division running with zero span");

  a_emit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (pixels_left_q == $past(pixels_left_q) - SPAN_W'(1)))
    else $error("pixel count not decremented on emit");

  a_busy_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != ST_IDLE) |-> !q_pop_o)
    else $error("queue consumed during segment setup");

endmodule

### tb/isometric_line_rasterizer_unit_checker.sv
// ----------------------------------------------------------------------------
// isometric_line_rasterizer_unit_checker
// Watches the register port and both queue sides of the rasteriser. It keeps
// its own copy of the registers and of the DDA state and works out each pixel
// when an item is taken. Every popped pixel is then compared field by field
// with the oldest expected one, and the mismatch count goes to the top.
// ----------------------------------------------------------------------------
module isometric_line_rasterizer_unit_checker import ilr_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                    push,
  input  logic                    full,
  input  logic                    cmd_i,
  input  logic [GRID_W-1:0]       grid_x_i,
  input  logic [GRID_W-1:0]       grid_y_i,
  input  logic                    direction_i,
  input  logic signed [Z_W-1:0]   z_start_i,
  input  logic signed [Z_W-1:0]   z_end_i,
  input  logic [COLOR_W-1:0]      color_i,
  input  logic                    empty,
  input  logic                    pop,
  input  logic signed [PIX_W-1:0] pixel_x_o,
  input  logic signed [PIX_W-1:0] pixel_y_o,
  input  logic [COLOR_W-1:0]      pixel_color_o,
  input  logic                    last_o,
  output int                      mismatch_count_o,
  output int                      pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ZOOM_W-1:0]         ZOOM_RESET = 8'd20;
  localparam logic signed [FACT_W-1:0]  COS_RESET  = 16'sd11415;
  localparam logic signed [FACT_W-1:0]  SIN_RESET  = 16'sd11754;

  typedef struct packed {
    logic signed [PIX_W-1:0] x;
    logic signed [PIX_W-1:0] y;
    logic [COLOR_W-1:0]      color;
    logic                    last;
  } pixel_t;

  pixel_t pending_pixels[$];

  logic [ZOOM_W-1:0]         zoom_q;
  logic signed [FACT_W-1:0]  cos_q;
  logic signed [FACT_W-1:0]  sin_q;
  logic signed [SHIFT_W-1:0] shift_x_q;
  logic signed [SHIFT_W-1:0] shift_y_q;

  logic signed [POS_W-1:0]   pos_x_q;
  logic signed [POS_W-1:0]   pos_y_q;
  logic signed [POS_W-1:0]   step_x_q;
  logic signed [POS_W-1:0]   step_y_q;
  logic [SPAN_W-1:0]         pixels_left_q;
  logic [COLOR_W-1:0]        seg_color_q;

  int errors;

  // saturate a q.14 coordinate, floor to the position format
  function automatic logic signed [POS_W-1:0] to_position(longint v);
    longint hi;
    longint lo;
    longint s;
    hi = (longint'(1) <<< (CLAMP_BITS + 14)) - 1;
    lo = -(longint'(1) <<< (CLAMP_BITS + 14));
    s = (v > hi) ? hi : ((v < lo) ? lo : v);
    s = (s >>> DOWN_SH) <<< UP_SH;
    return s[POS_W-1:0];
  endfunction

  function automatic void project_point(input longint gx, input longint gy, input longint z,
                                        output logic signed [POS_W-1:0] px,
                                        output logic signed [POS_W-1:0] py);
    longint zx;
    longint zy;
    zx = gx * longint'(zoom_q);
    zy = gy * longint'(zoom_q);
    px = to_position((zx - zy) * longint'(cos_q) + longint'(shift_x_q) * 16384);
    py = to_position((zx + zy) * longint'(sin_q) - z * 16384 + longint'(shift_y_q) * 16384);
  endfunction

  function automatic void check_field(string name, logic signed [31:0] want,
                                      logic signed [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : predict
    logic signed [POS_W-1:0] x0, y0, x1, y1;
    longint dx, dy, ax, ay, span;
    pixel_t want;
    if (!rst_ni) begin
      zoom_q        = ZOOM_RESET;
      cos_q         = COS_RESET;
      sin_q         = SIN_RESET;
      shift_x_q     = '0;
      shift_y_q     = '0;
      pos_x_q       = '0;
      pos_y_q       = '0;
      step_x_q      = '0;
      step_y_q      = '0;
      pixels_left_q = '0;
      seg_color_q   = '0;
      pending_pixels.delete();
      errors        = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ZOOM:    zoom_q    = cfg_data_i[ZOOM_W-1:0];
          CFG_COS:     cos_q     = cfg_data_i[FACT_W-1:0];
          CFG_SIN:     sin_q     = cfg_data_i[FACT_W-1:0];
          CFG_SHIFT_X: shift_x_q = cfg_data_i[SHIFT_W-1:0];
          CFG_SHIFT_Y: shift_y_q = cfg_data_i[SHIFT_W-1:0];
          default: ;
        endcase
      end

      if (pop && !empty) begin
        if (pending_pixels.size() == 0) begin
          $error("unexpected pixel x=%0d y=%0d", pixel_x_o, pixel_y_o);
          errors++;
        end else begin
          want = pending_pixels.pop_front();
          check_field("pixel_x", want.x, pixel_x_o);
          check_field("pixel_y", want.y, pixel_y_o);
          check_field("pixel_color", want.color, pixel_color_o);
          check_field("last", want.last, last_o);
        end
      end

      if (push && !full) begin
        if (cmd_i == CMD_LOAD) begin
          project_point(longint'(grid_x_i), longint'(grid_y_i), longint'(z_start_i), x0, y0);
          project_point(longint'(grid_x_i) + (direction_i ? 0 : 1),
                        longint'(grid_y_i) + (direction_i ? 1 : 0),
                        longint'(z_end_i), x1, y1);
          dx = longint'(x1) - longint'(x0);
          dy = longint'(y1) - longint'(y0);
          ax = (dx < 0) ? -dx : dx;
          ay = (dy < 0) ? -dy : dy;
          span = ((ax > ay) ? ax : ay) >>> FRAC_BITS;
          seg_color_q = color_i;
          pos_x_q     = x0;
          pos_y_q     = y0;
          if (span > 0) begin
            step_x_q      = POS_W'(dx / span);
            step_y_q      = POS_W'(dy / span);
            pixels_left_q = SPAN_W'(span);
          end else begin
            step_x_q      = '0;
            step_y_q      = '0;
            pixels_left_q = '0;
          end
        end else if (pixels_left_q != 0) begin
          want.x        = PIX_W'(longint'(pos_x_q) / (longint'(1) <<< FRAC_BITS));
          want.y        = PIX_W'(longint'(pos_y_q) / (longint'(1) <<< FRAC_BITS));
          want.color    = seg_color_q;
          pos_x_q       = pos_x_q + step_x_q;
          pos_y_q       = pos_y_q + step_y_q;
          pixels_left_q = pixels_left_q - 1'b1;
          want.last     = (pixels_left_q == 0);
          pending_pixels.push_back(want);
        end
      end
    end
    pending_o        = pending_pixels.size();
    mismatch_count_o = errors;
  end

endmodule

### tb/isometric_line_rasterizer_unit_test.sv
// ----------------------------------------------------------------------------
// isometric_line_rasterizer_unit_test
// Drives the rasteriser through several register settings, extremes and
// out-of-range values among them. Each setting gets load and tick items: a
// short directed set first (phase 0 only), then mostly well-formed segments
// with random content, mixed with lone ticks and wild loads. Both queue sides
// stall at random; a checker beside the block predicts and compares every pixel.
// ----------------------------------------------------------------------------
module isometric_line_rasterizer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ilr_pkg::*;

  localparam int NUM_PHASES   = 9;
  localparam int DRAIN_CYCLES = 200;
  localparam int STALL_LIMIT  = 5000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0]   cfg_data_i  = '0;
  logic                    push        = 1'b0;
  logic                    full;
  logic                    cmd_i       = 1'b0;
  logic [GRID_W-1:0]       grid_x_i    = '0;
  logic [GRID_W-1:0]       grid_y_i    = '0;
  logic                    direction_i = 1'b0;
  logic signed [Z_W-1:0]   z_start_i   = '0;
  logic signed [Z_W-1:0]   z_end_i     = '0;
  logic [COLOR_W-1:0]      color_i     = '0;
  logic                    empty;
  logic                    pop         = 1'b0;
  logic signed [PIX_W-1:0] pixel_x_o;
  logic signed [PIX_W-1:0] pixel_y_o;
  logic [COLOR_W-1:0]      pixel_color_o;
  logic                    last_o;

  int mismatches;
  int pending;
  int tx_idle_pct  = 0;
  int rx_idle_pct  = 0;
  int stall_cycles = 0;

  isometric_line_rasterizer_unit dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .push, .full, .cmd_i, .grid_x_i, .grid_y_i, .direction_i,
    .z_start_i, .z_end_i, .color_i,
    .empty, .pop, .pixel_x_o, .pixel_y_o, .pixel_color_o, .last_o
  );

  isometric_line_rasterizer_unit_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .push, .full, .cmd_i, .grid_x_i, .grid_y_i, .direction_i,
    .z_start_i, .z_end_i, .color_i,
    .empty, .pop, .pixel_x_o, .pixel_y_o, .pixel_color_o, .last_o,
    .mismatch_count_o(mismatches), .pending_o(pending)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    pop <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty) || cfg_we_i) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL isometric_line_rasterizer_unit");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_item(input cmd_e cmd, input logic [GRID_W-1:0] gx,
                           input logic [GRID_W-1:0] gy, input logic dir,
                           input logic signed [Z_W-1:0] zs,
                           input logic signed [Z_W-1:0] ze,
                           input logic [COLOR_W-1:0] col);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push        <= 1'b1;
    cmd_i       <= cmd;
    grid_x_i    <= gx;
    grid_y_i    <= gy;
    direction_i <= dir;
    z_start_i   <= zs;
    z_end_i     <= ze;
    color_i     <= col;
    do @(negedge clk_i); while (full);
    @(posedge clk_i);
  endtask

  task automatic send_ticks(input int count);
    repeat (count) begin
      send_item(CMD_TICK, GRID_W'($urandom), GRID_W'($urandom), 1'($urandom),
                Z_W'($urandom), Z_W'($urandom), COLOR_W'($urandom));
    end
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [CFG_DATA_W-1:0] rand_factor();
    return CFG_DATA_W'(int'($urandom_range(32768)) - 16384);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_shift();
    return CFG_DATA_W'(int'($urandom_range(8191)) - 4096);
  endfunction

  task automatic configure(input int phase);
    case (phase)
      1: begin
        write_reg(CFG_ZOOM, 16'd1);
        write_reg(CFG_COS, 16'd11415);
        write_reg(CFG_SIN, 16'd11754);
        write_reg(CFG_SHIFT_X, 16'd0);
        write_reg(CFG_SHIFT_Y, 16'd0);
      end
      2: begin
        write_reg(CFG_ZOOM, 16'd255);
        write_reg(CFG_COS, 16'd16384);
        write_reg(CFG_SIN, CFG_DATA_W'(-16384));
        write_reg(CFG_SHIFT_X, CFG_DATA_W'(-4096));
        write_reg(CFG_SHIFT_Y, 16'd4095);
      end
      3: begin
        // out-of-range values are used as given
        write_reg(CFG_ZOOM, 16'd0);
        write_reg(CFG_COS, 16'h8000);
        write_reg(CFG_SIN, 16'h7fff);
        write_reg(CFG_SHIFT_X, 16'd4095);
        write_reg(CFG_SHIFT_Y, CFG_DATA_W'(-4096));
      end
      5: begin
        write_reg(CFG_ZOOM, 16'd1);
        write_reg(CFG_COS, CFG_DATA_W'(-16384));
        write_reg(CFG_SIN, 16'd16384);
        write_reg(CFG_SHIFT_X, rand_shift());
        write_reg(CFG_SHIFT_Y, rand_shift());
      end
      7: begin
        write_reg(CFG_ZOOM, 16'd8);
        write_reg(CFG_COS, 16'd8192);
        write_reg(CFG_SIN, 16'd4096);
        write_reg(CFG_SHIFT_X, 16'd0);
        write_reg(CFG_SHIFT_Y, 16'd0);
      end
      8: begin
        write_reg(CFG_ZOOM, CFG_DATA_W'($urandom));
        write_reg(CFG_COS, CFG_DATA_W'($urandom));
        write_reg(CFG_SIN, CFG_DATA_W'($urandom));
        write_reg(CFG_SHIFT_X, CFG_DATA_W'($urandom));
        write_reg(CFG_SHIFT_Y, CFG_DATA_W'($urandom));
        cfg_we_i   <= 1'b1;
        cfg_idx_i  <= CFG_UNUSED;
        cfg_data_i <= CFG_DATA_W'($urandom);
        @(posedge clk_i);
      end
      default: begin
        write_reg(CFG_ZOOM, CFG_DATA_W'($urandom_range(40, 1)));
        write_reg(CFG_COS, rand_factor());
        write_reg(CFG_SIN, rand_factor());
        write_reg(CFG_SHIFT_X, rand_shift());
        write_reg(CFG_SHIFT_Y, rand_shift());
      end
    endcase
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_directed();
    // tick with nothing pending
    send_item(CMD_TICK, '0, '0, 1'b0, '0, '0, '0);
    // short segment drawn to its end, then one tick past it
    send_item(CMD_LOAD, '0, '0, 1'b0, '0, '0, '0);
    send_ticks(15);
    send_item(CMD_LOAD, 10'd1023, 10'd1023, 1'b1, 16'sh8000, 16'sh7fff, 24'hffffff);
    send_ticks(2);
    send_item(CMD_LOAD, 10'd1023, 10'd0, 1'b0, 16'sh7fff, 16'sh8000, 24'h123456);
    send_ticks(1);
    // load while drawing replaces the segment
    send_item(CMD_LOAD, 10'd0, 10'd1023, 1'b1, 16'sd0, 16'sd1, 24'haaaaaa);
    send_item(CMD_LOAD, 10'd5, 10'd7, 1'b0, 16'sd10, 16'sd10, 24'h555555);
    send_ticks(2);
  endtask

  task automatic run_random(input int count);
    int sent;
    int kind;
    int ticks;
    logic signed [Z_W-1:0] zs;
    logic signed [Z_W-1:0] ze;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(99);
      if (kind < 80) begin
        zs = Z_W'(int'($urandom_range(2000)) - 1000);
        ze = zs + Z_W'(int'($urandom_range(16)) - 8);
        ticks = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(24);
      end else if (kind < 90) begin
        send_ticks(1);
        sent++;
        continue;
      end else begin
        zs = Z_W'($urandom);
        ze = Z_W'($urandom);
        ticks = $urandom_range(4);
      end
      send_item(CMD_LOAD, GRID_W'($urandom), GRID_W'($urandom), 1'($urandom),
                zs, ze, COLOR_W'($urandom));
      send_ticks(ticks);
      sent += 1 + ticks;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase < 3) begin
        tx_idle_pct = 15;
        rx_idle_pct <= 52;
      end else if (phase < 6) begin
        tx_idle_pct = 52;
        rx_idle_pct <= 15;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end
      if (phase > 0) begin
        wait_drained();
        configure(phase);
      end
      if (phase == 0) begin
        run_directed();
      end
      run_random((phase == 0) ? 90 : 110);
      push <= 1'b0;
    end
    wait_drained();
    if (mismatches == 0) begin
      $display("PASS isometric_line_rasterizer_unit");
    end else begin
      $display("FAIL isometric_line_rasterizer_unit");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/ilr_pkg.sv
hw/rtl/ilr_front.sv
hw/rtl/ilr_fifo.sv
hw/rtl/ilr_back.sv
hw/rtl/isometric_line_rasterizer_unit.sv
tb/isometric_line_rasterizer_unit_checker.sv
tb/isometric_line_rasterizer_unit_test.sv
